// File: src/fcdma_pkg.sv
// ----------------------------------------------------------------------------
// fcdma_pkg
// Shared types, codes and count rules of the four-channel DMA sequencer.
// ----------------------------------------------------------------------------
package fcdma_pkg;

    localparam int NUM_CH = 4;

    typedef logic [1:0] chan_t;

    localparam logic [2:0] KIND_ENABLE = 3'd0;
    localparam logic [2:0] KIND_VBLANK = 3'd1;
    localparam logic [2:0] KIND_HBLANK = 3'd2;
    localparam logic [2:0] KIND_FIFO_A = 3'd3;
    localparam logic [2:0] KIND_FIFO_B = 3'd4;
    localparam logic [2:0] KIND_STEP   = 3'd5;

    localparam logic [1:0] TIMING_IMMEDIATE = 2'd0;
    localparam logic [1:0] TIMING_VBLANK    = 2'd1;
    localparam logic [1:0] TIMING_HBLANK    = 2'd2;
    localparam logic [1:0] TIMING_SPECIAL   = 2'd3;

    localparam logic [1:0] SRC_INC = 2'd0;
    localparam logic [1:0] SRC_DEC = 2'd1;

    localparam logic [1:0] DST_INC    = 2'd0;
    localparam logic [1:0] DST_DEC    = 2'd1;
    localparam logic [1:0] DST_RELOAD = 2'd3;

    localparam chan_t CH_FIFO_LO = 2'd1;
    localparam chan_t CH_FIFO_HI = 2'd2;
    localparam chan_t CH_LAST    = 2'd3;

    localparam logic [16:0] MAX_COUNT_LOW  = 17'd16384;
    localparam logic [16:0] MAX_COUNT_LAST = 17'd65536;
    localparam logic [16:0] FIFO_COUNT     = 17'd4;

    localparam logic [31:0] FIFO_A_ADDR = 32'h040000A0;
    localparam logic [31:0] FIFO_B_ADDR = 32'h040000A4;

    localparam logic [31:0] STEP_HALF = 32'd2;
    localparam logic [31:0] STEP_WORD = 32'd4;

    typedef struct packed {
        logic       irq_enable;
        logic       repeat_on;
        logic       transfer_32;
        logic [1:0] start_mode;
        logic [1:0] dst_mode;
        logic [1:0] src_mode;
    } ctrl_t;

    typedef struct packed {
        logic [2:0]  kind;
        chan_t       channel;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] unit_count;
        ctrl_t       ctrl;
    } item_t;

    typedef struct packed {
        logic        transfer_valid;
        chan_t       xfer_channel;
        logic [31:0] read_address;
        logic [31:0] write_address;
        logic        unit_is_32;
        logic        last_unit;
        logic        irq_raise;
    } result_t;

    function automatic logic fifo_mode(chan_t ch, ctrl_t ctrl);
        return (ch == CH_FIFO_LO || ch == CH_FIFO_HI) &&
               ctrl.start_mode == TIMING_SPECIAL;
    endfunction

    function automatic logic [16:0] load_count(chan_t ch, ctrl_t ctrl,
                                               logic [15:0] count);
        logic [16:0] cnt;
        if (fifo_mode(ch, ctrl)) begin
            cnt = FIFO_COUNT;
        end else if (count != 16'd0) begin
            cnt = {1'b0, count};
        end else if (ch == CH_LAST) begin
            cnt = MAX_COUNT_LAST;
        end else begin
            cnt = MAX_COUNT_LOW;
        end
        return cnt;
    endfunction

endpackage

// File: src/fcdma_core.sv
// ----------------------------------------------------------------------------
// fcdma_core
// Channel state and one-pass item decode: loads, restarts and unit steps.
// ----------------------------------------------------------------------------
module fcdma_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              item_valid,
    input  fcdma_pkg::item_t  item,
    output fcdma_pkg::result_t res
);
    import fcdma_pkg::*;

    logic [31:0] dst_register_reg  [NUM_CH];
    logic [15:0] count_register_reg[NUM_CH];
    ctrl_t       ctrl_reg          [NUM_CH];
    logic [31:0] src_ptr_reg       [NUM_CH];
    logic [31:0] dst_ptr_reg       [NUM_CH];
    logic [16:0] units_left_reg    [NUM_CH];
    logic [NUM_CH-1:0] enabled_reg;
    logic [NUM_CH-1:0] running_reg;
    logic              active_valid_reg;
    chan_t             active_ch_reg;

    logic [31:0] dst_register_next  [NUM_CH];
    logic [15:0] count_register_next[NUM_CH];
    ctrl_t       ctrl_next          [NUM_CH];
    logic [31:0] src_ptr_next       [NUM_CH];
    logic [31:0] dst_ptr_next       [NUM_CH];
    logic [16:0] units_left_next    [NUM_CH];
    logic [NUM_CH-1:0] enabled_next;
    logic [NUM_CH-1:0] running_next;
    logic              active_valid_next;
    chan_t             active_ch_next;

    logic        found;
    chan_t       sel;
    ctrl_t       sel_ctrl;
    logic        sel_fifo;
    logic        sel_wide;
    logic        sel_last;
    logic [31:0] delta;
    logic [1:0]  trig_timing;
    logic [31:0] trig_addr;

    always_comb begin
        found = 1'b0;
        sel   = '0;
        if (active_valid_reg && running_reg[active_ch_reg]) begin
            found = 1'b1;
            sel   = active_ch_reg;
        end else begin
            for (int i = NUM_CH - 1; i >= 0; i--) begin
                if (running_reg[i]) begin
                    found = 1'b1;
                    sel   = chan_t'(i);
                end
            end
        end
        sel_ctrl = ctrl_reg[sel];
        sel_fifo = fifo_mode(sel, sel_ctrl);
        sel_wide = sel_fifo || sel_ctrl.transfer_32;
        delta    = sel_wide ? STEP_WORD : STEP_HALF;
        sel_last = units_left_reg[sel] <= 17'd1;
    end

    always_comb begin
        trig_timing = (item.kind == KIND_VBLANK) ? TIMING_VBLANK : TIMING_HBLANK;
        trig_addr   = (item.kind == KIND_FIFO_A) ? FIFO_A_ADDR : FIFO_B_ADDR;
    end

    always_comb begin
        dst_register_next   = dst_register_reg;
        count_register_next = count_register_reg;
        ctrl_next           = ctrl_reg;
        src_ptr_next        = src_ptr_reg;
        dst_ptr_next        = dst_ptr_reg;
        units_left_next     = units_left_reg;
        enabled_next        = enabled_reg;
        running_next        = running_reg;
        active_valid_next   = active_valid_reg;
        active_ch_next      = active_ch_reg;
        res                 = '0;

        unique case (item.kind)
            KIND_ENABLE: begin
                dst_register_next[item.channel]   = item.dest_address;
                count_register_next[item.channel] = item.unit_count;
                ctrl_next[item.channel]           = item.ctrl;
                enabled_next[item.channel]        = 1'b1;
                units_left_next[item.channel]     =
                    load_count(item.channel, item.ctrl, item.unit_count);
                src_ptr_next[item.channel]        = item.source_address;
                dst_ptr_next[item.channel]        = item.dest_address;
                if (item.ctrl.start_mode == TIMING_IMMEDIATE) begin
                    running_next[item.channel] = 1'b1;
                end
            end
            KIND_VBLANK, KIND_HBLANK: begin
                for (int i = 0; i < NUM_CH; i++) begin
                    if (enabled_reg[i] && !running_reg[i] &&
                        ctrl_reg[i].start_mode == trig_timing) begin
                        running_next[i]    = 1'b1;
                        units_left_next[i] = load_count(chan_t'(i), ctrl_reg[i],
                                                        count_register_reg[i]);
                        if (ctrl_reg[i].dst_mode == DST_RELOAD) begin
                            dst_ptr_next[i] = dst_register_reg[i];
                        end
                    end
                end
            end
            KIND_FIFO_A, KIND_FIFO_B: begin
                for (int i = 1; i <= 2; i++) begin
                    if (enabled_reg[i] && !running_reg[i] &&
                        ctrl_reg[i].start_mode == TIMING_SPECIAL &&
                        dst_register_reg[i] == trig_addr) begin
                        running_next[i]    = 1'b1;
                        units_left_next[i] = load_count(chan_t'(i), ctrl_reg[i],
                                                        count_register_reg[i]);
                        if (ctrl_reg[i].dst_mode == DST_RELOAD) begin
                            dst_ptr_next[i] = dst_register_reg[i];
                        end
                    end
                end
            end
            KIND_STEP: begin
                if (!found) begin
                    active_valid_next = 1'b0;
                end else begin
                    active_valid_next  = 1'b1;
                    active_ch_next     = sel;
                    res.transfer_valid = 1'b1;
                    res.xfer_channel   = sel;
                    res.read_address   = src_ptr_reg[sel];
                    res.write_address  = dst_ptr_reg[sel];
                    res.unit_is_32     = sel_wide;

                    if (sel_ctrl.src_mode == SRC_INC) begin
                        src_ptr_next[sel] = src_ptr_reg[sel] + delta;
                    end else if (sel_ctrl.src_mode == SRC_DEC) begin
                        src_ptr_next[sel] = src_ptr_reg[sel] - delta;
                    end
                    if (!sel_fifo) begin
                        if (sel_ctrl.dst_mode == DST_INC ||
                            sel_ctrl.dst_mode == DST_RELOAD) begin
                            dst_ptr_next[sel] = dst_ptr_reg[sel] + delta;
                        end else if (sel_ctrl.dst_mode == DST_DEC) begin
                            dst_ptr_next[sel] = dst_ptr_reg[sel] - delta;
                        end
                    end

                    units_left_next[sel] = sel_last ? 17'd0
                                                    : units_left_reg[sel] - 17'd1;
                    if (sel_last) begin
                        res.last_unit     = 1'b1;
                        res.irq_raise     = sel_ctrl.irq_enable;
                        running_next[sel] = 1'b0;
                        if (!sel_ctrl.repeat_on ||
                            sel_ctrl.start_mode == TIMING_IMMEDIATE) begin
                            enabled_next[sel] = 1'b0;
                        end
                        active_valid_next = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CH; i++) begin
                dst_register_reg[i]   <= '0;
                count_register_reg[i] <= '0;
                ctrl_reg[i]           <= '0;
                src_ptr_reg[i]        <= '0;
                dst_ptr_reg[i]        <= '0;
                units_left_reg[i]     <= '0;
            end
            enabled_reg      <= '0;
            running_reg      <= '0;
            active_valid_reg <= 1'b0;
            active_ch_reg    <= '0;
        end else if (item_valid) begin
            dst_register_reg   <= dst_register_next;
            count_register_reg <= count_register_next;
            ctrl_reg           <= ctrl_next;
            src_ptr_reg        <= src_ptr_next;
            dst_ptr_reg        <= dst_ptr_next;
            units_left_reg     <= units_left_next;
            enabled_reg        <= enabled_next;
            running_reg        <= running_next;
            active_valid_reg   <= active_valid_next;
            active_ch_reg      <= active_ch_next;
        end
    end

endmodule

// File: src/four_channel_dma_controller.sv
// ----------------------------------------------------------------------------
// four_channel_dma_controller
// Four-channel DMA sequencer issuing one unit transfer per step beat that finds a running channel.
// ----------------------------------------------------------------------------
// Slave channel carries one command beat: tuser holds the kind (enable load,
// vblank, hblank, FIFO A request, FIFO B request, step), tdata the channel,
// addresses, count and control bits of an enable load.
// Master channel returns exactly one beat per slave beat, in order. For a
// step that finds a running channel it holds the unit transfer (channel,
// read and write address, size, interrupt flag), tuser[0] marks a valid
// transfer and tlast the unit that finishes the channel. Every other beat
// comes back with all fields zero.
// From slave accept to master valid: one input register, then one pass through
// the channel state logic into the result register. Throughput is one beat per
// cycle while the receiver does not stall; the channel state update of one beat
// is registered with its result and is visible to the next beat.
// When the receiver stalls, the result register holds and the input register
// fills, then s_tready drops; no beat is lost. Synchronous reset clears all
// channel state: no channel enabled or running, pointers and counts zero.
// ----------------------------------------------------------------------------
module four_channel_dma_controller (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // channel[1:0], source_address[33:2], dest_address[65:34],
    // unit_count[81:66], src_mode[83:82], dst_mode[85:84],
    // start_mode[87:86], transfer_32[88], repeat_on[89], irq_enable[90]
    input  logic [95:0] s_tdata,
    // kind[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // xfer_channel[1:0], read_address[33:2], write_address[65:34],
    // unit_is_32[66], irq_raise[67]
    output logic [71:0] m_tdata,
    // transfer_valid[0]
    output logic [0:0]  m_tuser,
    // last_unit
    output logic        m_tlast
);
    import fcdma_pkg::*;

    item_t   s_item;
    item_t   in_item_reg;
    logic    in_valid_reg;
    logic    in_valid_next;
    result_t core_res;
    result_t out_res_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    advance;
    logic    core_fire;
    logic    s_fire;

    always_comb begin
        s_item.kind                  = s_tuser;
        s_item.channel               = s_tdata[1:0];
        s_item.source_address        = s_tdata[33:2];
        s_item.dest_address          = s_tdata[65:34];
        s_item.unit_count            = s_tdata[81:66];
        s_item.ctrl.src_mode         = s_tdata[83:82];
        s_item.ctrl.dst_mode         = s_tdata[85:84];
        s_item.ctrl.start_mode       = s_tdata[87:86];
        s_item.ctrl.transfer_32      = s_tdata[88];
        s_item.ctrl.repeat_on        = s_tdata[89];
        s_item.ctrl.irq_enable       = s_tdata[90];
    end

    assign advance   = !out_valid_reg || m_tready;
    assign core_fire = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign s_fire    = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (core_fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (core_fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg <= s_item;
        end
        if (core_fire) begin
            out_res_reg <= core_res;
        end
    end

    fcdma_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (core_fire),
        .item       (in_item_reg),
        .res        (core_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0,
                       out_res_reg.irq_raise,
                       out_res_reg.unit_is_32,
                       out_res_reg.write_address,
                       out_res_reg.read_address,
                       out_res_reg.xfer_channel};
    assign m_tuser  = out_res_reg.transfer_valid;
    assign m_tlast  = out_res_reg.last_unit;

endmodule

// File: src/fcdma_checker.sv
// ----------------------------------------------------------------------------
// fcdma_checker
// Port-level checks of the DMA sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module fcdma_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    input  logic [0:0]  m_tuser,
    input  logic        m_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("master beat changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("master valid after reset");

    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 72'd0 && !m_tlast)
        else $error("idle beat carries transfer fields");

    a_last_is_xfer: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[0])
        else $error("last unit without a transfer");

    a_irq_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[67] |-> m_tlast)
        else $error("interrupt raised before the last unit");

endmodule

bind four_channel_dma_controller fcdma_checker u_fcdma_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// File: dv/tb_four_channel_dma_controller.sv
// ----------------------------------------------------------------------------
// tb_four_channel_dma_controller
// Self-checking bench for the four-channel DMA sequencer.
// ----------------------------------------------------------------------------
// A behavioral copy of the channel state (registers, pointers, unit counts,
// enable/running flags, the channel in progress) predicts the result of every
// accepted command beat. Results are compared field by field, in order.
// Directed tests cover idle results, address wrap, channel locking and
// priority, triggered restarts, FIFO mode and the count maximum. Random
// traffic mixes well-formed enable/trigger/step sequences with noise, under
// random sender gaps and receiver stalls, ending with a stretch of full rate.
// ----------------------------------------------------------------------------
module tb_four_channel_dma_controller;
    timeunit 1ns;
    timeprecision 1ps;

    import fcdma_pkg::*;

    localparam logic [2:0] KIND_RSVD_6   = 3'd6;
    localparam logic [2:0] KIND_RSVD_7   = 3'd7;
    localparam logic [1:0] SRC_FIXED     = 2'd2;
    localparam logic [1:0] SRC_FIXED_ALT = 2'd3;
    localparam logic [1:0] DST_FIXED     = 2'd2;
    localparam logic [2:0] NO_CHANNEL    = 3'd4;
    localparam int         CYCLE_LIMIT   = 1_000_000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    four_channel_dma_controller u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // channel state mirror
    logic [31:0] src_reg    [4] = '{default: '0};
    logic [31:0] dst_reg    [4] = '{default: '0};
    logic [15:0] count_reg  [4] = '{default: '0};
    ctrl_t       ctrl_reg   [4] = '{default: '0};
    logic        enabled    [4] = '{default: '0};
    logic        running    [4] = '{default: '0};
    logic [16:0] units_left [4] = '{default: '0};
    logic [31:0] src_ptr    [4] = '{default: '0};
    logic [31:0] dst_ptr    [4] = '{default: '0};
    logic [2:0]  active_ch = NO_CHANNEL;

    result_t pending_transfers [$];
    int      mismatch_count = 0;
    int      cycle_count = 0;
    int      counted_beats = 0;
    int      stall_left = 0;
    bit      gaps_on = 1'b1;
    bit      stalls_on = 1'b1;

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // random receiver backpressure in bursts
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (stalls_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 2);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic logic in_fifo_mode(chan_t c);
        return (c == CH_FIFO_LO || c == CH_FIFO_HI) &&
               ctrl_reg[c].start_mode == TIMING_SPECIAL;
    endfunction

    function automatic logic [16:0] reload_units(chan_t c);
        if (in_fifo_mode(c))
            return FIFO_COUNT;
        if (count_reg[c] != 16'd0)
            return {1'b0, count_reg[c]};
        return (c == CH_LAST) ? MAX_COUNT_LAST : MAX_COUNT_LOW;
    endfunction

    function automatic void restart_channel(chan_t c);
        if (running[c])
            return;
        running[c] = 1'b1;
        units_left[c] = reload_units(c);
        if (ctrl_reg[c].dst_mode == DST_RELOAD)
            dst_ptr[c] = dst_reg[c];
    endfunction

    function automatic void fire_timing(logic [1:0] timing);
        for (int i = 0; i < NUM_CH; i++) begin
            if (enabled[i] && ctrl_reg[i].start_mode == timing)
                restart_channel(chan_t'(i));
        end
    endfunction

    function automatic void fire_fifo(logic [31:0] addr);
        for (int i = CH_FIFO_LO; i <= CH_FIFO_HI; i++) begin
            if (enabled[i] && ctrl_reg[i].start_mode == TIMING_SPECIAL &&
                dst_reg[i] == addr)
                restart_channel(chan_t'(i));
        end
    endfunction

    function automatic result_t predict_transfer(item_t it);
        result_t     r;
        chan_t       c;
        logic        found;
        logic        fifo;
        logic        wide;
        logic        last;
        logic [31:0] delta;
        r = '0;
        c = it.channel;
        found = 1'b0;
        case (it.kind)
            KIND_ENABLE: begin
                src_reg[c] = it.source_address;
                dst_reg[c] = it.dest_address;
                count_reg[c] = it.unit_count;
                ctrl_reg[c] = it.ctrl;
                enabled[c] = 1'b1;
                units_left[c] = reload_units(c);
                src_ptr[c] = it.source_address;
                dst_ptr[c] = it.dest_address;
                if (it.ctrl.start_mode == TIMING_IMMEDIATE)
                    running[c] = 1'b1;
            end
            KIND_VBLANK: fire_timing(TIMING_VBLANK);
            KIND_HBLANK: fire_timing(TIMING_HBLANK);
            KIND_FIFO_A: fire_fifo(FIFO_A_ADDR);
            KIND_FIFO_B: fire_fifo(FIFO_B_ADDR);
            KIND_STEP: begin
                if (active_ch < NO_CHANNEL && running[active_ch[1:0]]) begin
                    c = active_ch[1:0];
                    found = 1'b1;
                end else begin
                    for (int i = NUM_CH - 1; i >= 0; i--) begin
                        if (running[i]) begin
                            c = chan_t'(i);
                            found = 1'b1;
                        end
                    end
                end
                if (!found) begin
                    active_ch = NO_CHANNEL;
                    return r;
                end
                active_ch = {1'b0, c};
                fifo = in_fifo_mode(c);
                wide = fifo || ctrl_reg[c].transfer_32;
                delta = wide ? STEP_WORD : STEP_HALF;
                r.transfer_valid = 1'b1;
                r.xfer_channel = c;
                r.read_address = src_ptr[c];
                r.write_address = dst_ptr[c];
                r.unit_is_32 = wide;
                case (ctrl_reg[c].src_mode)
                    SRC_INC: src_ptr[c] = src_ptr[c] + delta;
                    SRC_DEC: src_ptr[c] = src_ptr[c] - delta;
                    default: ;
                endcase
                if (!fifo) begin
                    case (ctrl_reg[c].dst_mode)
                        DST_INC, DST_RELOAD: dst_ptr[c] = dst_ptr[c] + delta;
                        DST_DEC: dst_ptr[c] = dst_ptr[c] - delta;
                        default: ;
                    endcase
                end
                last = units_left[c] <= 17'd1;
                units_left[c] = last ? 17'd0 : units_left[c] - 17'd1;
                if (last) begin
                    r.last_unit = 1'b1;
                    r.irq_raise = ctrl_reg[c].irq_enable;
                    running[c] = 1'b0;
                    if (!ctrl_reg[c].repeat_on ||
                        ctrl_reg[c].start_mode == TIMING_IMMEDIATE)
                        enabled[c] = 1'b0;
                    active_ch = NO_CHANNEL;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %h, got %h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin : result_monitor
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_transfers.size() == 0) begin
                $error("result beat with nothing expected");
                mismatch_count++;
            end else begin
                want = pending_transfers.pop_front();
                check_field("transfer_valid", 32'(want.transfer_valid), 32'(m_tuser[0]));
                check_field("xfer_channel", 32'(want.xfer_channel), 32'(m_tdata[1:0]));
                check_field("read_address", want.read_address, m_tdata[33:2]);
                check_field("write_address", want.write_address, m_tdata[65:34]);
                check_field("unit_is_32", 32'(want.unit_is_32), 32'(m_tdata[66]));
                check_field("irq_raise", 32'(want.irq_raise), 32'(m_tdata[67]));
                check_field("last_unit", 32'(want.last_unit), 32'(m_tlast));
            end
        end
    end

    task automatic send_beat(item_t it);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.kind;
        s_tdata <= {5'd0, it.ctrl, it.unit_count, it.dest_address,
                    it.source_address, it.channel};
        do @(posedge aclk); while (!s_tready);
        pending_transfers.push_back(predict_transfer(it));
        counted_beats++;
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_transfers.size() != 0);
    endtask

    function automatic item_t random_item();
        item_t      it;
        logic [8:0] bits;
        bits = 9'($urandom);
        it.kind = 3'($urandom_range(0, 7));
        it.channel = 2'($urandom);
        it.source_address = $urandom;
        it.dest_address = $urandom;
        it.unit_count = 16'($urandom);
        it.ctrl = bits;
        return it;
    endfunction

    function automatic item_t event_item(logic [2:0] kind);
        item_t it;
        it = random_item();
        it.kind = kind;
        return it;
    endfunction

    function automatic item_t enable_item(chan_t ch, logic [31:0] src, logic [31:0] dst,
                                          logic [15:0] count, logic [1:0] sm,
                                          logic [1:0] dm, logic [1:0] timing,
                                          logic t32, logic rep, logic irq);
        item_t it;
        it.kind = KIND_ENABLE;
        it.channel = ch;
        it.source_address = src;
        it.dest_address = dst;
        it.unit_count = count;
        it.ctrl = '{irq_enable: irq, repeat_on: rep, transfer_32: t32,
                    start_mode: timing, dst_mode: dm, src_mode: sm};
        return it;
    endfunction

    function automatic item_t random_enable();
        item_t it;
        it = event_item(KIND_ENABLE);
        case ($urandom_range(0, 9))
            0: it.unit_count = '0;
            1: ;
            default: it.unit_count = 16'($urandom_range(1, 6));
        endcase
        if (it.ctrl.start_mode == TIMING_SPECIAL && $urandom_range(0, 3) != 0)
            it.dest_address = $urandom_range(0, 1) ? FIFO_A_ADDR : FIFO_B_ADDR;
        return it;
    endfunction

    task automatic run_steps(int n);
        repeat (n) send_beat(event_item(KIND_STEP));
    endtask

    task automatic random_traffic(int target, bit vary_idling);
        item_t it;
        int    stop_at;
        stop_at = counted_beats + target;
        while (counted_beats < stop_at) begin
            if (vary_idling) begin
                gaps_on = $urandom_range(0, 3) != 0;
                stalls_on = $urandom_range(0, 3) != 0;
            end
            if ($urandom_range(0, 9) < 6) begin
                it = random_enable();
                send_beat(it);
                case (it.ctrl.start_mode)
                    TIMING_VBLANK: send_beat(event_item(KIND_VBLANK));
                    TIMING_HBLANK: send_beat(event_item(KIND_HBLANK));
                    TIMING_SPECIAL: send_beat(event_item(
                        it.dest_address == FIFO_B_ADDR ? KIND_FIFO_B : KIND_FIFO_A));
                    default: ;
                endcase
                run_steps($urandom_range(1, 8));
            end else begin
                send_beat(random_item());
            end
            if (vary_idling && $urandom_range(0, 29) == 0)
                wait_for_drain();
        end
    endtask

    task automatic test_idle_results();
        send_beat(event_item(KIND_STEP));
        send_beat(event_item(KIND_VBLANK));
        send_beat(event_item(KIND_HBLANK));
        send_beat(event_item(KIND_FIFO_A));
        send_beat(event_item(KIND_FIFO_B));
        send_beat(event_item(KIND_RSVD_6));
        send_beat(event_item(KIND_RSVD_7));
    endtask

    task automatic test_address_wrap();
        send_beat(enable_item(2'd0, 32'hFFFF_FFFE, 32'h0000_0000, 16'd2, SRC_INC, DST_DEC,
                              TIMING_IMMEDIATE, 1'b0, 1'b1, 1'b1));
        run_steps(2);
    endtask

    task automatic test_channel_lock();
        send_beat(enable_item(2'd2, 32'h1000_0000, 32'h2000_0000, 16'd2, SRC_FIXED_ALT,
                              DST_FIXED, TIMING_IMMEDIATE, 1'b0, 1'b0, 1'b0));
        run_steps(1);
        send_beat(enable_item(2'd0, 32'h0000_0000, 32'hFFFF_FFFC, 16'd1, SRC_DEC, DST_INC,
                              TIMING_IMMEDIATE, 1'b1, 1'b0, 1'b1));
        run_steps(2);
    endtask

    task automatic test_triggered_restart();
        send_beat(enable_item(2'd1, 32'h0300_0000, 32'h0600_0000, 16'd1, SRC_FIXED,
                              DST_RELOAD, TIMING_HBLANK, 1'b0, 1'b1, 1'b0));
        send_beat(event_item(KIND_HBLANK));
        run_steps(1);
        send_beat(event_item(KIND_HBLANK));
        run_steps(1);
    endtask

    task automatic test_fifo_mode();
        send_beat(enable_item(2'd2, 32'h0200_0000, FIFO_B_ADDR, 16'd9, SRC_INC, DST_DEC,
                              TIMING_SPECIAL, 1'b0, 1'b1, 1'b1));
        send_beat(event_item(KIND_FIFO_A));
        send_beat(event_item(KIND_FIFO_B));
        run_steps(4);
    endtask

    // zero count must not end the run early; reload with one unit to finish it
    task automatic test_count_maximum();
        send_beat(enable_item(2'd0, $urandom, $urandom, 16'd0, SRC_INC, DST_INC,
                              TIMING_IMMEDIATE, 1'b0, 1'b0, 1'b1));
        run_steps(3);
        send_beat(enable_item(2'd0, $urandom, $urandom, 16'd1, SRC_INC, DST_INC,
                              TIMING_IMMEDIATE, 1'b0, 1'b0, 1'b1));
        run_steps(1);
        send_beat(enable_item(2'd3, $urandom, $urandom, 16'd0, SRC_DEC, DST_DEC,
                              TIMING_IMMEDIATE, 1'b1, 1'b0, 1'b1));
        run_steps(3);
        send_beat(enable_item(2'd3, $urandom, $urandom, 16'd1, SRC_DEC, DST_DEC,
                              TIMING_IMMEDIATE, 1'b1, 1'b0, 1'b1));
        run_steps(1);
    endtask

    task automatic test_random_traffic();
        random_traffic(150, 1'b1);
        wait_for_drain();
        random_traffic(150, 1'b1);
    endtask

    task automatic test_full_rate_tail();
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        random_traffic(60, 1'b0);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_idle_results();
        test_address_wrap();
        test_channel_lock();
        test_triggered_restart();
        test_fifo_mode();
        test_count_maximum();
        test_random_traffic();
        test_full_rate_tail();
        wait_for_drain();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && pending_transfers.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/fcdma_pkg.sv
src/fcdma_core.sv
src/four_channel_dma_controller.sv
src/fcdma_checker.sv
dv/tb_four_channel_dma_controller.sv
